### hw/rtl/flm_pkg.sv
// flm_pkg: shared types, constants and the case-folding function of the
// fixed-string line matcher. No dependencies; used by every module of the block.

package flm_pkg;

    // fixed pattern storage given by the four 64-bit pattern words
    localparam int PATTERN_SLOTS   = 32;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int LEN_W           = 6;
    localparam int CHAR_W          = 8;
    localparam int LINE_NUM_W      = 32;
    localparam int OUT_TDATA_W     = 40;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_WORD_0 = 3'd0,
        REG_PATTERN_WORD_1 = 3'd1,
        REG_PATTERN_WORD_2 = 3'd2,
        REG_PATTERN_WORD_3 = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_CASE_FOLD      = 3'd5
    } flm_reg_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic              advance;
        logic              file_start;
        logic              line_end;
        logic              case_fold;
        logic [CHAR_W-1:0] char_folded;
    } flm_cell_ctrl_t;

    typedef struct packed {
        logic                  any_match;
        logic [LINE_NUM_W-1:0] line_number;
        logic                  line_matched;
    } flm_result_t;

    // ascii a-z folding, upper to lower
    function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] b,
                                                    input logic ic);
        logic [CHAR_W-1:0] r;
        r = b;
        if (ic && (b >= 8'h41) && (b <= 8'h5A)) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

### hw/rtl/flm_cell.sv
// flm_cell: one position of the shift-and match chain; holds one partial-match
// bit and passes it to its right-hand neighbour. Depends on flm_pkg.

module flm_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  flm_pkg::flm_cell_ctrl_t   ctrl,
    input  logic [flm_pkg::CHAR_W-1:0] pattern_byte,
    input  logic                      active,
    input  logic                      last,
    input  logic                      prev_bit,
    output logic                      match_bit,
    output logic                      hit
);
    import flm_pkg::*;

    logic match_reg;
    logic match_next;
    logic cmp_bit;

    assign cmp_bit = active & prev_bit
                   & (fold_byte(pattern_byte, ctrl.case_fold) == ctrl.char_folded);

    // the last active cell flags a full pattern ending at this byte
    assign hit = cmp_bit & last;

    always_comb begin
        match_next = match_reg;
        if (ctrl.advance) begin
            match_next = ctrl.line_end ? 1'b0 : cmp_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign match_bit = match_reg;

endmodule

### hw/rtl/flm_result_buf.sv
// flm_result_buf: two-entry output register with skid stage for result beats,
// so input beats keep flowing while a result waits. Depends on flm_pkg.

module flm_result_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  flm_pkg::flm_result_t push_data,
    output logic                 push_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output flm_pkg::flm_result_t out_data
);
    import flm_pkg::*;

    logic        main_valid_reg;
    logic        main_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    flm_result_t main_data_reg;
    flm_result_t main_data_next;
    flm_result_t skid_data_reg;
    flm_result_t skid_data_next;
    logic        pop;

    assign pop        = main_valid_reg & out_ready;
    assign push_ready = ~skid_valid_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end else begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // skid entry is only ever filled behind a full main entry
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid without main entry");

    // upstream is held off whenever the skid entry is in use
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

endmodule

### hw/rtl/fixed_string_line_matcher.sv
// fixed_string_line_matcher: top level; configuration registers, line and file
// bookkeeping, the cell chain and the result buffer. Depends on flm_pkg,
// flm_cell and flm_result_buf.
//
// Takes one text byte per clock on the s_ channel and searches each line for a
// literal pattern of up to 32 bytes, with optional a-z case folding. The
// search is a chain of cells, one per pattern byte, that all update in the
// same cycle as the byte is taken, so a new byte is accepted every cycle while
// s_tready is high. A byte marked with s_tlast closes its line and gives one
// result beat, registered in the result buffer, on the m_ channel; the buffer
// holds two beats, and s_tready drops only while both are waiting. s_tuser
// marks the first byte of a file and restarts line numbering. Configuration
// writes are always taken and apply from the next byte on.

module fixed_string_line_matcher #(
    parameter int MAX_PATTERN = flm_pkg::MAX_PATTERN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // [7:0] char_byte
    input  logic [7:0]                         s_tdata,
    input  logic                               s_tlast,
    // [0] file_start
    input  logic [0:0]                         s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] line_matched, [32:1] line_number, [33] any_match, [39:34] zero
    output logic [flm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [flm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [flm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import flm_pkg::*;

    localparam int NUM_CELLS = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;
    localparam int PAD_W     = OUT_TDATA_W - LINE_NUM_W - 2;

    logic [PATTERN_SLOTS*CHAR_W-1:0] pattern_reg;
    logic [LEN_W-1:0]                length_reg;
    logic                            case_fold_reg;
    logic                            line_hit_reg;
    logic                            line_hit_next;
    logic [LINE_NUM_W-1:0]           line_count_reg;
    logic [LINE_NUM_W-1:0]           line_count_next;
    logic                            seen_match_reg;
    logic                            seen_match_next;

    logic [LEN_W-1:0]                eff_len;
    logic                            accept;
    flm_cell_ctrl_t                  ctrl;
    logic [NUM_CELLS-1:0]            cell_bits;
    logic [NUM_CELLS-1:0]            cell_hits;
    logic                            hit_now;
    logic                            lh_now;
    logic [LINE_NUM_W-1:0]           count_base;
    logic [LINE_NUM_W-1:0]           count_inc;
    logic                            matched;
    logic                            push;
    flm_result_t                     push_data;
    flm_result_t                     out_data;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg   <= '0;
            length_reg    <= '0;
            case_fold_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (flm_reg_t'(cfg_index))
                REG_PATTERN_WORD_0: pattern_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PATTERN_WORD_1: pattern_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PATTERN_WORD_2: pattern_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PATTERN_WORD_3: pattern_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PATTERN_LENGTH: length_reg    <= cfg_data[LEN_W-1:0];
                REG_CASE_FOLD:      case_fold_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // lengths beyond the cell count clamp to it
    assign eff_len = (length_reg > LEN_W'(NUM_CELLS)) ? LEN_W'(NUM_CELLS) : length_reg;

    assign accept = s_tvalid & s_tready;

    always_comb begin
        ctrl.advance     = accept;
        ctrl.file_start  = s_tuser[0];
        ctrl.line_end    = s_tlast;
        ctrl.case_fold   = case_fold_reg;
        ctrl.char_folded = fold_byte(s_tdata, case_fold_reg);
    end

    // cell chain
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        logic prev_bit;
        if (i == 0) begin : g_head
            assign prev_bit = 1'b1;
        end else begin : g_body
            // a file start wipes the vector before the byte is compared
            assign prev_bit = cell_bits[i-1] & ~ctrl.file_start;
        end

        flm_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .pattern_byte (pattern_reg[i*CHAR_W +: CHAR_W]),
            .active       (eff_len > LEN_W'(i)),
            .last         (eff_len == LEN_W'(i + 1)),
            .prev_bit     (prev_bit),
            .match_bit    (cell_bits[i]),
            .hit          (cell_hits[i])
        );
    end

    assign hit_now    = |cell_hits;
    assign lh_now     = (line_hit_reg & ~ctrl.file_start) | hit_now;
    assign count_base = ctrl.file_start ? '0 : line_count_reg;
    assign count_inc  = (&count_base) ? count_base : count_base + 1'b1;
    assign matched    = (eff_len == '0) ? 1'b1 : lh_now;

    always_comb begin
        line_hit_next   = line_hit_reg;
        line_count_next = line_count_reg;
        seen_match_next = seen_match_reg;
        if (accept) begin
            if (s_tlast) begin
                line_hit_next   = 1'b0;
                line_count_next = count_inc;
                seen_match_next = seen_match_reg | matched;
            end else begin
                line_hit_next   = lh_now;
                line_count_next = count_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_hit_reg   <= 1'b0;
            line_count_reg <= '0;
            seen_match_reg <= 1'b0;
        end else begin
            line_hit_reg   <= line_hit_next;
            line_count_reg <= line_count_next;
            seen_match_reg <= seen_match_next;
        end
    end

    // result beat
    assign push = accept & s_tlast;

    always_comb begin
        push_data.line_matched = matched;
        push_data.line_number  = count_inc;
        push_data.any_match    = seen_match_reg | matched;
    end

    flm_result_buf u_result_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {PAD_W'(0), out_data.any_match, out_data.line_number,
                      out_data.line_matched};

    // any_match never falls once set
    a_seen_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_match_reg |=> seen_match_reg)
        else $error("any_match flag cleared");

    // a line end leaves the partial-match vector and line hit empty
    a_line_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> ((cell_bits == '0) && !line_hit_reg))
        else $error("match state survived a line end");

endmodule
